>>> design/bbd_pkg.sv
package bbd_pkg;

   // Port and field widths fixed by the stream format.
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 80;
   localparam int RSP_PAD_BITS   = 4;
   localparam int OUT_BITS       = 16;
   localparam int X_BITS         = 12;
   localparam int ROW_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CFG_WIDTH_BITS = 13;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_BAYER_PATTERN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BAYER_RGGB = 2'd0,
      BAYER_BGGR = 2'd1,
      BAYER_GRBG = 2'd2,
      BAYER_GBRG = 2'd3
   } bayer_type;

   typedef enum logic [1:0] {
      COL_RED   = 2'd0,
      COL_GREEN = 2'd1,
      COL_BLUE  = 2'd2
   } color_type;

   // Describes where the output pixel sits inside the 3x3 window and which
   // of its neighbors lie inside the image.
   typedef struct packed {
      bayer_type pattern;
      logic      row_shift;  // center on window row 2, no row below it
      logic      col_shift;  // center on window column 2, no column right of it
      logic      x_odd;
      logic      y_odd;
      logic      top_ok;     // the row above the center is inside the image
      logic      left_ok;    // the column left of the center is inside the image
   } pix_ctrl_type;

   // Color filter at a pixel, given the parity of its coordinates.
   function automatic color_type site_color(bayer_type pat, logic x_odd, logic y_odd);
      logic red_x;
      logic red_y;
      logic on_red_col;
      logic on_red_row;
      red_x      = (pat == BAYER_BGGR) || (pat == BAYER_GRBG);
      red_y      = (pat == BAYER_BGGR) || (pat == BAYER_GBRG);
      on_red_col = (x_odd == red_x);
      on_red_row = (y_odd == red_y);
      if (on_red_col && on_red_row) begin
         return COL_RED;
      end else if (!on_red_col && !on_red_row) begin
         return COL_BLUE;
      end else begin
         return COL_GREEN;
      end
   endfunction

endpackage

>>> design/bayer_bilinear_demosaic.sv
// Path of a raw sample to rsp: accept stage register, window stage, output register.
// Throughput: one raw sample per cycle while rsp does not stall and each sample yields at
// most one pixel; a sample with more pixels (row ends, last row) is held by the output stage.
// Reset is synchronous and active high: it clears the pipeline, the window, the position
// counters and the registers (width 2, height 2, RGGB). The line stores are not cleared and
// need no clearing pass: a row is always written before it is used.
module bayer_bilinear_demosaic #(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Raw sample stream.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bbd_pkg::REQ_DATA_BITS-1:0]    req_tdata,   // [15:0] raw_sample
   input  logic                                 req_tuser,   // [0] frame_start
   // Pixel stream.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bbd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // [15:0] red, [31:16] green,
                                                             // [47:32] blue, [59:48] pixel_x,
                                                             // [75:60] pixel_y, [79:76] zero
   output logic                                 rsp_tlast,   // run_last
   output logic                                 rsp_tuser,   // [0] frame_done
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bbd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bbd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int CB      = $clog2(MAX_WIDTH);
   localparam int WB      = $clog2(MAX_WIDTH + 1);
   localparam int RB      = bbd_pkg::ROW_BITS;
   localparam int IN_BITS = (SAMPLE_BITS < bbd_pkg::REQ_DATA_BITS) ? SAMPLE_BITS
                                                                   : bbd_pkg::REQ_DATA_BITS;

   // ------------------------------------------------------------------
   // Registers. Width and height are stored already clamped to their
   // usable range, so the datapath never has to clamp.
   // ------------------------------------------------------------------
   logic [WB-1:0]       width_ff;
   logic [RB-1:0]       height_ff;
   bbd_pkg::bayer_type  pattern_ff;
   logic [31:0]         csr_w_raw;
   logic [WB-1:0]       csr_w_clamp;
   logic [RB-1:0]       csr_h_clamp;

   assign csr_ready = 1'b1;
   assign csr_w_raw = 32'(csr_data[bbd_pkg::CFG_WIDTH_BITS-1:0]);

   always_comb begin
      if (csr_w_raw < 32'd2) begin
         csr_w_clamp = WB'(2);
      end else if (csr_w_raw > 32'(MAX_WIDTH)) begin
         csr_w_clamp = WB'(MAX_WIDTH);
      end else begin
         csr_w_clamp = WB'(csr_w_raw);
      end
      csr_h_clamp = (csr_data < 16'd2) ? RB'(2) : RB'(csr_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WB'(2);
         height_ff  <= RB'(2);
         pattern_ff <= bbd_pkg::BAYER_RGGB;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bbd_pkg::CSR_IMAGE_WIDTH:   width_ff   <= csr_w_clamp;
            bbd_pkg::CSR_IMAGE_HEIGHT:  height_ff  <= csr_h_clamp;
            bbd_pkg::CSR_BAYER_PATTERN: pattern_ff <= bbd_pkg::bayer_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Accept stage: position tracking and the line store read.
   // A frame_start flag, or a position left outside the frame by a change
   // of the registers, restarts the position at (0,0). After the last
   // pixel of a frame the position wraps to (0,0) by itself.
   // ------------------------------------------------------------------
   logic                   req_accept;
   logic [CB-1:0]          col_ff;
   logic [RB-1:0]          row_ff;
   logic                   restart;
   logic [CB-1:0]          c_acc;
   logic [RB-1:0]          r_acc;
   logic                   col_last;
   logic                   row_last;
   logic [3:0]             mask_acc;
   logic [SAMPLE_BITS-1:0] sample_acc;

   logic                   s1_valid_ff;
   logic                   s1_fire;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CB-1:0]          s1_col_ff;
   logic [RB-1:0]          s1_row_ff;
   logic [3:0]             s1_mask_ff;

   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;
   assign sample_acc = SAMPLE_BITS'(req_tdata[IN_BITS-1:0]);

   assign restart  = req_tuser || (WB'(col_ff) >= width_ff) || (row_ff >= height_ff);
   assign c_acc    = restart ? '0 : col_ff;
   assign r_acc    = restart ? '0 : row_ff;
   assign col_last = (WB'(c_acc) == width_ff - WB'(1));
   assign row_last = (r_acc == height_ff - RB'(1));

   // The pixels that become complete with this sample, in emission order:
   // bit 0 (c-1, r-1), bit 1 (c, r-1), bit 2 (c-1, r), bit 3 (c, r).
   assign mask_acc[0] = (r_acc != '0) && (c_acc != '0);
   assign mask_acc[1] = (r_acc != '0) && col_last;
   assign mask_acc[2] = row_last && (c_acc != '0);
   assign mask_acc[3] = row_last && col_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (col_last) begin
            col_ff <= '0;
            row_ff <= row_last ? '0 : r_acc + RB'(1);
         end else begin
            col_ff <= c_acc + CB'(1);
            row_ff <= r_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= sample_acc;
         s1_col_ff    <= c_acc;
         s1_row_ff    <= r_acc;
         s1_mask_ff   <= mask_acc;
      end
   end

   // ------------------------------------------------------------------
   // Line stores. Both rows of one column share a word: the low half is
   // row r-2, the high half row r-1. The word is read when the sample is
   // accepted and written back one stage later. When the next sample reads
   // the same column in the cycle of that write (a restart on column 0),
   // the written word is forwarded instead of the stale read data.
   // ------------------------------------------------------------------
   logic [2*SAMPLE_BITS-1:0] ram_rd_data;
   logic [2*SAMPLE_BITS-1:0] ram_wr_data;
   logic [2*SAMPLE_BITS-1:0] line_pair;
   logic                     fwd_ff;
   logic [2*SAMPLE_BITS-1:0] fwd_data_ff;
   logic [SAMPLE_BITS-1:0]   line_a_old;
   logic [SAMPLE_BITS-1:0]   line_b_old;

   assign line_pair   = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign line_a_old  = line_pair[SAMPLE_BITS-1:0];
   assign line_b_old  = line_pair[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign ram_wr_data = {s1_sample_ff, line_b_old};

   bbd_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (c_acc),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_ff <= s1_fire && (c_acc == s1_col_ff);
      end else if (s1_fire) begin
         fwd_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_data_ff <= ram_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Window stage. The 3x3 window shifts left by one column when the
   // stage fires; the new right column is rows r-2, r-1 and r.
   // The stage fires only when the emit stage is free or hands over its
   // last pixel in this cycle, because that stage reads the window.
   // ------------------------------------------------------------------
   logic [2:0][2:0][SAMPLE_BITS-1:0] win_ff;
   logic [3:0]                       s2_mask_ff;
   logic [CB-1:0]                    s2_col_ff;
   logic [RB-1:0]                    s2_row_ff;
   logic                             s2_busy;
   logic                             s2_step;
   logic                             s2_last;
   logic                             s2_free;
   logic                             rsp_free;
   logic                             rsp_valid_ff;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign s2_busy  = |s2_mask_ff;
   assign s2_step  = s2_busy && rsp_free;
   assign s2_last  = (s2_mask_ff & (s2_mask_ff - 4'd1)) == 4'd0;
   assign s2_free  = !s2_busy || (s2_step && s2_last);
   assign s1_fire  = s1_valid_ff && s2_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_fire) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= line_a_old;
         win_ff[1][2] <= line_b_old;
         win_ff[2][2] <= s1_sample_ff;
      end
   end

   // ------------------------------------------------------------------
   // Emit stage: hands out the pending pixels of one sample, lowest mask
   // bit first, one per cycle into the output register while it is free.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else if (s1_fire) begin
         s2_mask_ff <= s1_mask_ff;
      end else if (s2_step) begin
         s2_mask_ff <= s2_mask_ff & (s2_mask_ff - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   logic [3:0]             sel;
   logic                   up_row;
   logic                   left_col;
   logic [CB-1:0]          px;
   logic [RB-1:0]          py;
   logic                   frame_done;
   bbd_pkg::pix_ctrl_type  pix_ctrl;
   logic [SAMPLE_BITS-1:0] pix_red;
   logic [SAMPLE_BITS-1:0] pix_green;
   logic [SAMPLE_BITS-1:0] pix_blue;

   assign sel      = s2_mask_ff & (~s2_mask_ff + 4'd1);
   assign up_row   = sel[0] || sel[1];
   assign left_col = sel[0] || sel[2];
   assign px       = left_col ? s2_col_ff - CB'(1) : s2_col_ff;
   assign py       = up_row ? s2_row_ff - RB'(1) : s2_row_ff;

   assign frame_done = (WB'(px) == width_ff - WB'(1)) && (py == height_ff - RB'(1));

   assign pix_ctrl.pattern   = pattern_ff;
   assign pix_ctrl.row_shift = !up_row;
   assign pix_ctrl.col_shift = !left_col;
   assign pix_ctrl.x_odd     = px[0];
   assign pix_ctrl.y_odd     = py[0];
   assign pix_ctrl.top_ok    = (py != '0);
   assign pix_ctrl.left_ok   = (px != '0);

   bbd_pixel #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_pixel (
      .win   (win_ff),
      .ctrl  (pix_ctrl),
      .red   (pix_red),
      .green (pix_green),
      .blue  (pix_blue)
   );

   // ------------------------------------------------------------------
   // Output register. It is reloaded in the cycle its transaction
   // completes, so a pixel can leave every cycle.
   // ------------------------------------------------------------------
   logic [bbd_pkg::OUT_BITS-1:0] rsp_red_ff;
   logic [bbd_pkg::OUT_BITS-1:0] rsp_green_ff;
   logic [bbd_pkg::OUT_BITS-1:0] rsp_blue_ff;
   logic [bbd_pkg::X_BITS-1:0]   rsp_x_ff;
   logic [RB-1:0]                rsp_y_ff;
   logic                         rsp_last_ff;
   logic                         rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_step) begin
         rsp_red_ff   <= bbd_pkg::OUT_BITS'(pix_red);
         rsp_green_ff <= bbd_pkg::OUT_BITS'(pix_green);
         rsp_blue_ff  <= bbd_pkg::OUT_BITS'(pix_blue);
         rsp_x_ff     <= bbd_pkg::X_BITS'(px);
         rsp_y_ff     <= py;
         rsp_last_ff  <= s2_last;
         rsp_done_ff  <= frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{bbd_pkg::RSP_PAD_BITS{1'b0}}, rsp_y_ff, rsp_x_ff,
                        rsp_blue_ff, rsp_green_ff, rsp_red_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The bottom-right pixel of a frame is always the last pixel of its sample.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_done pixel without tlast");

   // A forwarded line word only exists for a sample waiting in the window stage.
   a_fwd_with_item: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("line store forward flag without a pending sample");

   // While the window stage stalls, the line store read data must hold.
   a_ram_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> $stable(ram_rd_data))
      else $error("line store read data changed during a stall");

endmodule

>>> design/bbd_ram.sv
module bbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents before a write to the same address in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bbd_pixel.sv
module bbd_pixel #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic [2:0][2:0][SAMPLE_BITS-1:0] win,
   input  bbd_pkg::pix_ctrl_type            ctrl,
   output logic [SAMPLE_BITS-1:0]           red,
   output logic [SAMPLE_BITS-1:0]           green,
   output logic [SAMPLE_BITS-1:0]           blue
);

   localparam int SUM_BITS = SAMPLE_BITS + 3;
   localparam int T_BITS   = SAMPLE_BITS + 3;
   localparam int K        = SAMPLE_BITS + 6;
   localparam int M_BITS   = SAMPLE_BITS + 4;
   localparam int P_BITS   = T_BITS + M_BITS;
   localparam logic [M_BITS-1:0] RECIP6 = M_BITS'(((64'd1 << K) + 64'd5) / 64'd6);

   // Rounded mean for one, two or four contributors.
   function automatic logic [SAMPLE_BITS-1:0] avg_pow2(logic [SUM_BITS-1:0] s,
                                                      logic [2:0] n);
      logic [SUM_BITS-1:0] r;
      unique case (n)
         3'd1:    r = s;
         3'd2:    r = (s + SUM_BITS'(1)) >> 1;
         3'd4:    r = (s + SUM_BITS'(2)) >> 2;
         default: r = '0;
      endcase
      return SAMPLE_BITS'(r);
   endfunction

   // Green is the only color that can have three contributors (an edge
   // next to a red or blue center); (2*sum+3)/6 is done by a reciprocal.
   function automatic logic [SAMPLE_BITS-1:0] avg_green(logic [SUM_BITS-1:0] s,
                                                       logic [2:0] n);
      logic [T_BITS-1:0] t;
      logic [P_BITS-1:0] prod;
      t    = T_BITS'(s << 1) + T_BITS'(3);
      prod = P_BITS'(t) * P_BITS'(RECIP6);
      if (n == 3'd3) begin
         return prod[K +: SAMPLE_BITS];
      end else begin
         return avg_pow2(s, n);
      end
   endfunction

   logic [2:0][SUM_BITS-1:0] sum;
   logic [2:0][2:0]          cnt;
   bbd_pkg::color_type       center_color;
   logic [SAMPLE_BITS-1:0]   center;
   logic [1:0]               center_row;
   logic [1:0]               center_col;

   always_comb begin
      sum = '0;
      cnt = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic [1:0]         ri;
            logic [1:0]         cj;
            logic               ok;
            bbd_pkg::color_type c;
            ri = 2'(i) + 2'(ctrl.row_shift);
            cj = 2'(j) + 2'(ctrl.col_shift);
            ok = (ri != 2'd3) && (cj != 2'd3) && (ctrl.top_ok || (i != 0))
                 && (ctrl.left_ok || (j != 0));
            c  = bbd_pkg::site_color(ctrl.pattern, ctrl.x_odd ^ (j != 1),
                                     ctrl.y_odd ^ (i != 1));
            if (ok) begin
               sum[c] = sum[c] + SUM_BITS'(win[ri][cj]);
               cnt[c] = cnt[c] + 3'd1;
            end
         end
      end
   end

   assign center_row   = ctrl.row_shift ? 2'd2 : 2'd1;
   assign center_col   = ctrl.col_shift ? 2'd2 : 2'd1;
   assign center       = win[center_row][center_col];
   assign center_color = bbd_pkg::site_color(ctrl.pattern, ctrl.x_odd, ctrl.y_odd);

   assign red   = (center_color == bbd_pkg::COL_RED) ? center
                : avg_pow2(sum[bbd_pkg::COL_RED], cnt[bbd_pkg::COL_RED]);
   assign green = (center_color == bbd_pkg::COL_GREEN) ? center
                : avg_green(sum[bbd_pkg::COL_GREEN], cnt[bbd_pkg::COL_GREEN]);
   assign blue  = (center_color == bbd_pkg::COL_BLUE) ? center
                : avg_pow2(sum[bbd_pkg::COL_BLUE], cnt[bbd_pkg::COL_BLUE]);

endmodule
